/* hdl/wavhp_pkg.sv */
// Shared types, constants and helpers for the WAV header parser.
// No dependencies; imported by every module of the block.
`default_nettype none

package wavhp_pkg;

    localparam int BYTE_W   = 8;
    localparam int OFFSET_W = 9;
    localparam int STATUS_W = 4;
    localparam int ALIGN_W  = 16;
    localparam int RATE_W   = 32;
    localparam int WINDOW_W = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int OUT_DATA_W = 208;   // 205 bits of fields, padded to bytes

    localparam int QUEUE_DEPTH_DEF = 4;

    // Register defaults
    localparam logic [ALIGN_W-1:0]  ALIGN_RESET  = 16'd4;
    localparam logic [RATE_W-1:0]   RATE_RESET   = 32'd64000;
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 8'd200;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_ALIGN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_RATE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW      = 2'd2;

    // Chunk identifiers as seen in a little-endian assembly word
    localparam logic [31:0] ID_RIFF = 32'h4646_4952;
    localparam logic [31:0] ID_WAVE = 32'h4556_4157;
    localparam logic [31:0] ID_FMT  = 32'h2074_6D66;

    // Fixed header offsets
    localparam logic [OFFSET_W-1:0] OFS_RIFF_ID   = 9'd3;
    localparam logic [OFFSET_W-1:0] OFS_RIFF_SIZE = 9'd7;
    localparam logic [OFFSET_W-1:0] OFS_WAVE_ID   = 9'd11;
    localparam logic [OFFSET_W-1:0] OFS_FMT_ID    = 9'd15;
    localparam logic [OFFSET_W-1:0] OFS_TAG       = 9'd21;
    localparam logic [OFFSET_W-1:0] OFS_CHANNELS  = 9'd23;
    localparam logic [OFFSET_W-1:0] OFS_RATE      = 9'd27;
    localparam logic [OFFSET_W-1:0] OFS_BYTE_RATE = 9'd31;
    localparam logic [OFFSET_W-1:0] OFS_ALIGN     = 9'd33;
    localparam logic [OFFSET_W-1:0] OFS_BITS      = 9'd35;
    localparam logic [OFFSET_W-1:0] OFS_MAX       = 9'd511;

    // Verdict codes
    localparam logic [STATUS_W-1:0] ST_OK        = 4'd0;
    localparam logic [STATUS_W-1:0] ST_NO_RIFF   = 4'd1;
    localparam logic [STATUS_W-1:0] ST_NO_WAVE   = 4'd2;
    localparam logic [STATUS_W-1:0] ST_NO_FMT    = 4'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_TAG   = 4'd4;
    localparam logic [STATUS_W-1:0] ST_NO_DATA   = 4'd5;
    localparam logic [STATUS_W-1:0] ST_ALIGN     = 4'd6;
    localparam logic [STATUS_W-1:0] ST_RATE      = 4'd7;
    localparam logic [STATUS_W-1:0] ST_TRUNCATED = 4'd8;

    // Format tags accepted
    localparam logic [15:0] TAG_PCM    = 16'h0001;
    localparam logic [15:0] TAG_FLOAT  = 16'h0003;
    localparam logic [15:0] TAG_ALAW   = 16'h0006;
    localparam logic [15:0] TAG_MULAW  = 16'h0007;
    localparam logic [15:0] TAG_EXTENS = 16'hFFFE;

    // Front-end parse phase
    typedef enum logic [2:0] {
        PH_WAIT,
        PH_HEAD,
        PH_SEARCH,
        PH_DSIZE,
        PH_DONE
    } phase_t;

    // What the back end does with one byte
    typedef enum logic [3:0] {
        OP_SHIFT,
        OP_CHK_RIFF,
        OP_CAP_RIFF,
        OP_CHK_WAVE,
        OP_CHK_FMT,
        OP_CAP_TAG,
        OP_CAP_CHAN,
        OP_CAP_RATE,
        OP_CAP_BRATE,
        OP_CAP_ALIGN,
        OP_CAP_BITS,
        OP_NO_DATA,
        OP_DSIZE
    } op_t;

    // Classified item passed from front to back
    typedef struct packed {
        logic [BYTE_W-1:0]   data_byte;
        op_t                 op;
        logic                first;
        logic                last;
        logic [OFFSET_W-1:0] hlen;
    } cmd_t;

    // Bytes of the "data" chunk id, in stream order
    function automatic logic [BYTE_W-1:0] data_id_byte(input logic [1:0] idx);
        logic [BYTE_W-1:0] r;
        case (idx)
            2'd0:    r = 8'h64;
            2'd1:    r = 8'h61;
            2'd2:    r = 8'h74;
            default: r = 8'h61;
        endcase
        return r;
    endfunction

    function automatic logic tag_ok(input logic [15:0] t);
        return (t == TAG_PCM) || (t == TAG_FLOAT) || (t == TAG_ALAW) ||
               (t == TAG_MULAW) || (t == TAG_EXTENS);
    endfunction

endpackage

`default_nettype wire

/* hdl/wav_header_parser_unit.sv */
// WAV RIFF header parser, top level: register file, front end, queue, back end.
// Depends on wavhp_pkg, wavhp_front, wavhp_queue and wavhp_back.
//
// Usage:
//   Bytes of a WAV file stream in on s_tdata, one item per byte; s_tuser marks
//   the first byte of a file (restarts the parse), s_tlast the final byte.
//   Bytes before any first byte, and after a file's verdict, are dropped.
//   Each file yields exactly one verdict item on the m_ channel, carrying the
//   status, header length (zero unless OK) and all header fields captured so far.
//   Throughput: one byte per cycle while s_tready is high; the front end
//   classifies each byte in the cycle it is accepted and the back end executes
//   one command per cycle from the queue unless a verdict waits on m_tready.
//   Verdict path: the byte that decides a verdict is written into the queue;
//   when the back end executes it, the verdict is registered in the output register.
//   Stall: while a verdict waits with m_tready low the back end holds; the
//   queue keeps taking bytes until it is full, then s_tready drops.
//   Reset (aresetn low, synchronous): parser waits for a first byte, queue and output
//   are emptied, registers return to align 4, byte rate 64000, window 200. The user
//   must write registers via cfg_we/cfg_index/cfg_wdata while idle; the block does not check.
`default_nettype none

module wav_header_parser_unit #(
    parameter int QUEUE_DEPTH = wavhp_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    // Input bytes
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    input  wire  [7:0]                          s_tdata,   // [7:0] data_byte
    input  wire                                 s_tuser,   // [0] first
    input  wire                                 s_tlast,
    // Verdicts
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    // [3:0] status, [12:4] header_length, [44:13] riff_size,
    // [60:45] format_tag, [76:61] channels, [108:77] sample_rate,
    // [140:109] byte_rate, [156:141] block_align, [172:157] bits_per_sample,
    // [204:173] data_size, [207:205] zero
    output logic [wavhp_pkg::OUT_DATA_W-1:0]    m_tdata,
    // Configuration writes
    input  wire                                 cfg_we,
    input  wire  [wavhp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire  [wavhp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import wavhp_pkg::*;

    logic [ALIGN_W-1:0]  align_cfg_reg;
    logic [RATE_W-1:0]   rate_cfg_reg;
    logic [WINDOW_W-1:0] window_cfg_reg;

    logic q_push, q_pop, q_full, q_empty;
    cmd_t push_cmd, head_cmd;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            align_cfg_reg  <= ALIGN_RESET;
            rate_cfg_reg   <= RATE_RESET;
            window_cfg_reg <= WINDOW_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_BLOCK_ALIGN: align_cfg_reg  <= cfg_wdata[ALIGN_W-1:0];
                CFG_BYTE_RATE:   rate_cfg_reg   <= cfg_wdata[RATE_W-1:0];
                CFG_WINDOW:      window_cfg_reg <= cfg_wdata[WINDOW_W-1:0];
                default: begin
                    align_cfg_reg <= align_cfg_reg;
                end
            endcase
        end
    end

    wavhp_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_byte       (s_tdata),
        .in_first      (s_tuser),
        .in_last       (s_tlast),
        .q_full        (q_full),
        .search_window (window_cfg_reg),
        .in_ready      (s_tready),
        .q_push        (q_push),
        .q_cmd         (push_cmd)
    );

    wavhp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .full     (q_full),
        .empty    (q_empty),
        .head_cmd (head_cmd)
    );

    wavhp_back u_back (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .q_empty              (q_empty),
        .q_cmd                (head_cmd),
        .expected_block_align (align_cfg_reg),
        .expected_byte_rate   (rate_cfg_reg),
        .q_pop                (q_pop),
        .out_valid            (m_tvalid),
        .out_ready            (m_tready),
        .out_data             (m_tdata)
    );

endmodule

`default_nettype wire

/* hdl/wavhp_front.sv */
// Front end: accepts bytes, tracks offset and phase, searches for the data id
// and classifies each byte into a command. Depends on wavhp_pkg.
`default_nettype none

module wavhp_front (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              in_valid,
    input  wire  [wavhp_pkg::BYTE_W-1:0]     in_byte,
    input  wire                              in_first,
    input  wire                              in_last,
    input  wire                              q_full,
    input  wire  [wavhp_pkg::WINDOW_W-1:0]   search_window,
    output logic                             in_ready,
    output logic                             q_push,
    output wavhp_pkg::cmd_t                  q_cmd
);
    import wavhp_pkg::*;

    phase_t                phase_reg, phase_next;
    logic [OFFSET_W-1:0]   offset_reg, offset_next;
    logic [2:0]            match_reg, match_next;
    logic [WINDOW_W-1:0]   window_reg, window_next;

    // Effective state after a possible restart on the first byte
    phase_t                phase_eff;
    logic [OFFSET_W-1:0]   offset_eff;
    logic [2:0]            match_eff;
    logic [WINDOW_W-1:0]   window_eff;
    logic                  accept;
    logic                  active;
    logic [WINDOW_W-1:0]   window_inc;
    logic [2:0]            match_step;
    logic [2:0]            dsize_inc;
    logic                  window_over;

    assign in_ready   = !q_full;
    assign accept     = in_valid && !q_full;
    assign phase_eff  = in_first ? PH_HEAD : phase_reg;
    assign offset_eff = in_first ? '0 : offset_reg;
    assign match_eff  = in_first ? '0 : match_reg;
    assign window_eff = in_first ? '0 : window_reg;
    assign active     = (phase_eff == PH_HEAD) || (phase_eff == PH_SEARCH) ||
                        (phase_eff == PH_DSIZE);
    assign window_over = (window_eff >= search_window);
    assign window_inc  = window_eff + 1'b1;
    assign dsize_inc   = match_eff + 1'b1;

    // Restarting match: a mismatching 'd' opens a new match
    always_comb begin
        if (in_byte == data_id_byte(match_eff[1:0])) begin
            match_step = match_eff + 1'b1;
        end else if (in_byte == data_id_byte(2'd0)) begin
            match_step = 3'd1;
        end else begin
            match_step = 3'd0;
        end
    end

    // Next state
    always_comb begin
        phase_next  = phase_reg;
        offset_next = offset_reg;
        match_next  = match_reg;
        window_next = window_reg;
        if (accept) begin
            phase_next  = phase_eff;
            offset_next = offset_eff;
            match_next  = match_eff;
            window_next = window_eff;
            if (active) begin
                if (offset_eff != OFS_MAX) begin
                    offset_next = offset_eff + 1'b1;
                end
                case (phase_eff)
                    PH_HEAD: begin
                        if (offset_eff == OFS_BITS) begin
                            phase_next  = PH_SEARCH;
                            match_next  = '0;
                            window_next = '0;
                        end
                    end
                    PH_SEARCH: begin
                        if (window_over) begin
                            phase_next = PH_DONE;
                        end else begin
                            window_next = window_inc;
                            if (match_step[2]) begin
                                phase_next = PH_DSIZE;
                                match_next = '0;
                            end else if (window_inc >= search_window) begin
                                phase_next = PH_DONE;
                            end else begin
                                match_next = match_step;
                            end
                        end
                    end
                    PH_DSIZE: begin
                        match_next = dsize_inc;
                        if (dsize_inc[2]) begin
                            phase_next = PH_DONE;
                        end
                    end
                    default: begin
                        phase_next = phase_eff;
                    end
                endcase
            end
        end
    end

    // Command output
    always_comb begin
        q_push          = accept && active;
        q_cmd.data_byte = in_byte;
        q_cmd.first     = in_first;
        q_cmd.last      = in_last;
        q_cmd.hlen      = offset_eff + 1'b1;
        q_cmd.op        = OP_SHIFT;
        case (phase_eff)
            PH_HEAD: begin
                case (offset_eff)
                    OFS_RIFF_ID:   q_cmd.op = OP_CHK_RIFF;
                    OFS_RIFF_SIZE: q_cmd.op = OP_CAP_RIFF;
                    OFS_WAVE_ID:   q_cmd.op = OP_CHK_WAVE;
                    OFS_FMT_ID:    q_cmd.op = OP_CHK_FMT;
                    OFS_TAG:       q_cmd.op = OP_CAP_TAG;
                    OFS_CHANNELS:  q_cmd.op = OP_CAP_CHAN;
                    OFS_RATE:      q_cmd.op = OP_CAP_RATE;
                    OFS_BYTE_RATE: q_cmd.op = OP_CAP_BRATE;
                    OFS_ALIGN:     q_cmd.op = OP_CAP_ALIGN;
                    OFS_BITS:      q_cmd.op = OP_CAP_BITS;
                    default:       q_cmd.op = OP_SHIFT;
                endcase
            end
            PH_SEARCH: begin
                if (window_over) begin
                    q_cmd.op = OP_NO_DATA;
                end else if (!match_step[2] && (window_inc >= search_window)) begin
                    q_cmd.op = OP_NO_DATA;
                end
            end
            PH_DSIZE: begin
                if (dsize_inc[2]) begin
                    q_cmd.op = OP_DSIZE;
                end
            end
            default: begin
                q_cmd.op = OP_SHIFT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_WAIT;
            offset_reg <= '0;
            match_reg  <= '0;
            window_reg <= '0;
        end else begin
            phase_reg  <= phase_next;
            offset_reg <= offset_next;
            match_reg  <= match_next;
            window_reg <= window_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/wavhp_queue.sv */
// Short command queue between the front and back ends of the parser.
// Depends on wavhp_pkg for the command type.
`default_nettype none

module wavhp_queue #(
    parameter int DEPTH = wavhp_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  push,
    input  wire  wavhp_pkg::cmd_t push_cmd,
    input  wire                  pop,
    output logic                 full,
    output logic                 empty,
    output wavhp_pkg::cmd_t      head_cmd
);
    import wavhp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full     = (count_reg == FULL_CNT);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_cmd = mem[rd_ptr_reg];

    // Storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* hdl/wavhp_back.sv */
// Back end: assembles words, captures header fields, runs the checks and
// holds the verdict in an output register. Depends on wavhp_pkg.
`default_nettype none

module wavhp_back (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               q_empty,
    input  wire  wavhp_pkg::cmd_t             q_cmd,
    input  wire  [wavhp_pkg::ALIGN_W-1:0]     expected_block_align,
    input  wire  [wavhp_pkg::RATE_W-1:0]      expected_byte_rate,
    output logic                              q_pop,
    output logic                              out_valid,
    input  wire                               out_ready,
    output logic [wavhp_pkg::OUT_DATA_W-1:0]  out_data
);
    import wavhp_pkg::*;

    logic [31:0] word_reg, word_next;
    logic [31:0] riff_reg, riff_next;
    logic [15:0] tag_reg, tag_next;
    logic [15:0] chan_reg, chan_next;
    logic [31:0] rate_reg, rate_next;
    logic [31:0] brate_reg, brate_next;
    logic [15:0] align_reg, align_next;
    logic [15:0] bits_reg, bits_next;
    logic [31:0] dsize_reg, dsize_next;
    logic        done_reg, done_next;
    logic        valid_reg;
    logic [OUT_DATA_W-1:0] data_reg;

    logic                  done_eff;
    logic                  emit;
    logic [STATUS_W-1:0]   status;
    logic [OFFSET_W-1:0]   hlen;

    assign q_pop     = !q_empty && (!valid_reg || out_ready);
    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign done_eff  = q_cmd.first ? 1'b0 : done_reg;

    // Execute one command
    always_comb begin
        word_next  = q_cmd.first ? '0 : word_reg;
        riff_next  = q_cmd.first ? '0 : riff_reg;
        tag_next   = q_cmd.first ? '0 : tag_reg;
        chan_next  = q_cmd.first ? '0 : chan_reg;
        rate_next  = q_cmd.first ? '0 : rate_reg;
        brate_next = q_cmd.first ? '0 : brate_reg;
        align_next = q_cmd.first ? '0 : align_reg;
        bits_next  = q_cmd.first ? '0 : bits_reg;
        dsize_next = q_cmd.first ? '0 : dsize_reg;
        done_next  = done_eff;
        emit       = 1'b0;
        status     = ST_OK;
        hlen       = '0;
        if (!done_eff) begin
            word_next = {q_cmd.data_byte, word_next[31:8]};
            case (q_cmd.op)
                OP_CHK_RIFF: begin
                    if (word_next != ID_RIFF) begin
                        emit = 1'b1; status = ST_NO_RIFF;
                    end
                end
                OP_CAP_RIFF: riff_next = word_next;
                OP_CHK_WAVE: begin
                    if (word_next != ID_WAVE) begin
                        emit = 1'b1; status = ST_NO_WAVE;
                    end
                end
                OP_CHK_FMT: begin
                    if (word_next != ID_FMT) begin
                        emit = 1'b1; status = ST_NO_FMT;
                    end
                end
                OP_CAP_TAG: begin
                    tag_next = word_next[31:16];
                    if (!tag_ok(word_next[31:16])) begin
                        emit = 1'b1; status = ST_BAD_TAG;
                    end
                end
                OP_CAP_CHAN:  chan_next  = word_next[31:16];
                OP_CAP_RATE:  rate_next  = word_next;
                OP_CAP_BRATE: brate_next = word_next;
                OP_CAP_ALIGN: align_next = word_next[31:16];
                OP_CAP_BITS:  bits_next  = word_next[31:16];
                OP_NO_DATA: begin
                    emit = 1'b1; status = ST_NO_DATA;
                end
                OP_DSIZE: begin
                    dsize_next = word_next;
                    emit       = 1'b1;
                    if (align_next != expected_block_align) begin
                        status = ST_ALIGN;
                    end else if (brate_next != expected_byte_rate) begin
                        status = ST_RATE;
                    end else begin
                        status = ST_OK;
                        hlen   = q_cmd.hlen;
                    end
                end
                default: begin
                    emit = 1'b0;
                end
            endcase
            // A last byte that gave no verdict ends the file as truncated
            if (!emit && q_cmd.last) begin
                emit   = 1'b1;
                status = ST_TRUNCATED;
            end
            done_next = emit;
        end
    end

    // Captured fields
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            word_reg  <= word_next;
            riff_reg  <= riff_next;
            tag_reg   <= tag_next;
            chan_reg  <= chan_next;
            rate_reg  <= rate_next;
            brate_reg <= brate_next;
            align_reg <= align_next;
            bits_reg  <= bits_next;
            dsize_reg <= dsize_next;
        end
        if (q_pop && emit) begin
            data_reg <= {3'b000, dsize_next, bits_next, align_next, brate_next,
                         rate_next, chan_next, tag_next, riff_next, hlen, status};
        end
    end

    // Verdict flag and output handshake
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            if (q_pop) begin
                done_reg <= done_next;
            end
            if (q_pop && emit) begin
                valid_reg <= 1'b1;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire
